/* rtl/vsd_pkg.sv */
// Shared types, constants and branch-cost function for the K=7 soft Viterbi decoder.
// No dependencies.
package vsd_pkg;

    localparam int NUM_STATES = 64;
    localparam int STATE_W    = 6;
    localparam int REG_W      = 7;
    localparam int SOFT_W     = 8;
    localparam int COST_W     = 9;
    localparam int METRIC_W   = 16;
    localparam int BEST_W     = 9;

    localparam logic [REG_W-1:0] GEN_FIRST  = 7'h6d;
    localparam logic [REG_W-1:0] GEN_SECOND = 7'h4f;
    localparam logic [STATE_W-1:0] LAST_STATE = 6'd63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN1,
        S_DRAIN2,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               load;
        logic               issue;
        logic [STATE_W-1:0] addr;
        logic               finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // cost of a branch: soft value, or its complement where the code bit is 1
    function automatic logic [COST_W-1:0] branch_cost(
        input logic [REG_W-1:0]  enc,
        input logic [SOFT_W-1:0] sa,
        input logic [SOFT_W-1:0] sb
    );
        logic [SOFT_W-1:0] ca;
        logic [SOFT_W-1:0] cb;
        ca = sa ^ {SOFT_W{^(enc & GEN_FIRST)}};
        cb = sb ^ {SOFT_W{^(enc & GEN_SECOND)}};
        return {1'b0, ca} + {1'b0, cb};
    endfunction

endpackage

/* rtl/vsd_ctrl.sv */
// Sequencer for the decoder: accepts a transaction, sweeps the 64 next states,
// drains the datapath pipeline and commits the result. Depends on vsd_pkg.
module vsd_ctrl
    import vsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t             state_reg;
    state_t             state_next;
    logic [STATE_W-1:0] cnt_reg;
    logic [STATE_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.addr   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STATE)
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/vsd_datapath.sv */
// Add-compare-select datapath: ping-pong metric and survivor memories, best-state
// tracking, renormalization offset, traceback fill and output register. Depends on vsd_pkg.
module vsd_datapath
    import vsd_pkg::*;
#(
    parameter int TRACEBACK = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [SOFT_W-1:0] soft_first,
    input  logic [SOFT_W-1:0] soft_second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              bit_valid,
    output logic              decoded_bit,
    output logic [BEST_W-1:0] best_metric
);

    localparam int FILL_W = $clog2(TRACEBACK);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(TRACEBACK - 1);
    localparam int ADDR_W = STATE_W + 1;

    logic [METRIC_W-1:0]  metric_mem [0:2*NUM_STATES-1];
    logic [TRACEBACK-1:0] path_mem   [0:2*NUM_STATES-1];

    logic                  bank_reg;
    logic                  fresh_reg;
    logic [NUM_STATES-1:0] reach_reg;
    logic [NUM_STATES-1:0] nreach_reg;
    logic [METRIC_W-1:0]   offset_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [SOFT_W-1:0]     sa_reg;
    logic [SOFT_W-1:0]     sb_reg;

    // stage 1: memory read
    logic                 v1_reg;
    logic [STATE_W-1:0]   nx1_reg;
    logic                 r0_1_reg;
    logic                 r1_1_reg;
    logic [METRIC_W-1:0]  m0_rd_reg;
    logic [METRIC_W-1:0]  m1_rd_reg;
    logic [TRACEBACK-1:0] p0_rd_reg;
    logic [TRACEBACK-1:0] p1_rd_reg;

    // stage 2: candidate metrics
    logic                 v2_reg;
    logic [STATE_W-1:0]   nx2_reg;
    logic                 r0_2_reg;
    logic                 r1_2_reg;
    logic [METRIC_W-1:0]  c0_reg;
    logic [METRIC_W-1:0]  c1_reg;
    logic [TRACEBACK-1:0] p0_2_reg;
    logic [TRACEBACK-1:0] p1_2_reg;

    logic                found_reg;
    logic [METRIC_W-1:0] bestm_reg;
    logic                btop_reg;

    logic              out_valid_reg;
    logic              bit_valid_reg;
    logic              decoded_bit_reg;
    logic [BEST_W-1:0] best_metric_reg;

    logic [ADDR_W-1:0]    rd0_addr;
    logic [ADDR_W-1:0]    rd1_addr;
    logic [METRIC_W-1:0]  c0_next;
    logic [METRIC_W-1:0]  c1_next;
    logic [TRACEBACK-1:0] p0_next;
    logic [TRACEBACK-1:0] p1_next;
    logic                 take1;
    logic                 new_reach;
    logic [METRIC_W-1:0]  sel_metric;
    logic [TRACEBACK-1:0] sel_path;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 last_step;

    function automatic logic [METRIC_W-1:0] cand_metric(
        input logic [METRIC_W-1:0] old_metric,
        input logic [COST_W-1:0]   cost
    );
        logic [METRIC_W:0] sum;
        sum = {1'b0, old_metric} + {{(METRIC_W+1-COST_W){1'b0}}, cost};
        return sum[METRIC_W] ? {METRIC_W{1'b1}} : sum[METRIC_W-1:0];
    endfunction

    assign rd0_addr = {bank_reg, 1'b0, cmd.addr[STATE_W-1:1]};
    assign rd1_addr = {bank_reg, 1'b1, cmd.addr[STATE_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            m0_rd_reg <= metric_mem[rd0_addr];
            m1_rd_reg <= metric_mem[rd1_addr];
            p0_rd_reg <= path_mem[rd0_addr];
            p1_rd_reg <= path_mem[rd1_addr];
            nx1_reg   <= cmd.addr;
            r0_1_reg  <= reach_reg[{1'b0, cmd.addr[STATE_W-1:1]}];
            r1_1_reg  <= reach_reg[{1'b1, cmd.addr[STATE_W-1:1]}];
        end
    end

    // old metrics come back renormalized by subtracting the previous best
    always_comb
    begin
        logic [METRIC_W-1:0] old0;
        logic [METRIC_W-1:0] old1;
        old0    = fresh_reg ? '0 : m0_rd_reg - offset_reg;
        old1    = fresh_reg ? '0 : m1_rd_reg - offset_reg;
        p0_next = fresh_reg ? '0 : p0_rd_reg;
        p1_next = fresh_reg ? '0 : p1_rd_reg;
        c0_next = cand_metric(old0, branch_cost({1'b0, nx1_reg}, sa_reg, sb_reg));
        c1_next = cand_metric(old1, branch_cost({1'b1, nx1_reg}, sa_reg, sb_reg));
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            nx2_reg  <= nx1_reg;
            r0_2_reg <= r0_1_reg;
            r1_2_reg <= r1_1_reg;
            c0_reg   <= c0_next;
            c1_reg   <= c1_next;
            p0_2_reg <= p0_next;
            p1_2_reg <= p1_next;
        end
    end

    // lower predecessor wins ties
    assign take1      = r1_2_reg && (!r0_2_reg || (c1_reg < c0_reg));
    assign new_reach  = v2_reg && (r0_2_reg || r1_2_reg);
    assign sel_metric = take1 ? c1_reg : c0_reg;
    assign sel_path   = take1 ? {p1_2_reg[TRACEBACK-2:0], nx2_reg[0]}
                              : {p0_2_reg[TRACEBACK-2:0], nx2_reg[0]};
    assign wr_addr    = {~bank_reg, nx2_reg};

    always_ff @(posedge clk)
    begin
        if (new_reach)
        begin
            metric_mem[wr_addr] <= sel_metric;
            path_mem[wr_addr]   <= sel_path;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sa_reg <= soft_first;
            sb_reg <= soft_second;
        end
        if (new_reach && (!found_reg || (sel_metric < bestm_reg)))
        begin
            bestm_reg <= sel_metric;
            btop_reg  <= sel_path[TRACEBACK-1];
        end
    end

    assign last_step = (fill_reg == FILL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            reach_reg     <= {{(NUM_STATES-1){1'b0}}, 1'b1};
            nreach_reg    <= '0;
            offset_reg    <= '0;
            fill_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.load)
            begin
                nreach_reg <= '0;
                found_reg  <= 1'b0;
            end
            else if (new_reach)
            begin
                nreach_reg[nx2_reg] <= 1'b1;
                found_reg           <= 1'b1;
            end
            if (cmd.finish)
            begin
                bank_reg      <= ~bank_reg;
                fresh_reg     <= 1'b0;
                reach_reg     <= nreach_reg;
                offset_reg    <= bestm_reg;
                fill_reg      <= last_step ? fill_reg : fill_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            bit_valid_reg   <= last_step;
            decoded_bit_reg <= last_step & btop_reg;
            best_metric_reg <= bestm_reg[BEST_W-1:0];
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign bit_valid     = bit_valid_reg;
    assign decoded_bit   = decoded_bit_reg;
    assign best_metric   = best_metric_reg;

endmodule

/* rtl/viterbi_soft_decoder_k7_unit.sv */
// Soft-decision Viterbi decoder, rate 1/2, K=7, one soft pair per transaction.
// A transaction is accepted, then swept in 64 ACS steps through the shared add-compare-select
// unit, drained from the pipeline (S_DRAIN1, S_DRAIN2) and committed once the output is free.
// A new pair is accepted only after the previous one commits; the ACS sweep is one-state-per-cycle.
// Reset (async, active low): only state 0 reachable with metric 0, empty survivors.
module viterbi_soft_decoder_k7_unit
    import vsd_pkg::*;
#(
    parameter int TRACEBACK = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SOFT_W-1:0] soft_first,
    input  logic [SOFT_W-1:0] soft_second,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              bit_valid,
    output logic              decoded_bit,
    output logic [BEST_W-1:0] best_metric
);

    cmd_t  cmd;
    stat_t stat;

    vsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vsd_datapath #(
        .TRACEBACK (TRACEBACK)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .soft_first  (soft_first),
        .soft_second (soft_second),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bit_valid   (bit_valid),
        .decoded_bit (decoded_bit),
        .best_metric (best_metric)
    );

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a step is in progress");

    // a result only appears at commit, never straight from idle
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result loaded outside commit");

endmodule
